### design/depthwise_conv_3tap_requant_defines.svh
// assertion macros for the depthwise convolution block
// used by the top level rtl file, no other dependencies
`ifndef DEPTHWISE_CONV_3TAP_REQUANT_DEFINES_SVH
`define DEPTHWISE_CONV_3TAP_REQUANT_DEFINES_SVH
`ifndef SYNTHESIS
`define DCR_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("dcr assertion failed");
`define DCR_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("dcr forbidden state");
`else
`define DCR_ASSERT(lbl, clk, rst, prop)
`define DCR_NEVER(lbl, clk, rst, expr)
`endif
`endif

### design/dcr_pkg.sv
// types and constants of the depthwise convolution block
// no dependencies
package dcr_pkg;
   localparam logic REG_ACT_MIN = 1'b0;
   localparam logic REG_ACT_MAX = 1'b1;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_MAC  = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   typedef struct packed {
      logic signed [5:0]  shift;
      logic signed [31:0] mult;
      logic signed [31:0] bias;
      logic signed [7:0]  w2;
      logic signed [7:0]  w1;
      logic signed [7:0]  w0;
   } param_type;

   typedef struct packed {
      logic rd;
      logic mac;
      logic mul;
   } stage_type;
endpackage

### design/dcr_store.sv
// per-channel storage: parameter memory, sample history memory, fill counts
// depends on dcr_pkg
module dcr_store #(
   parameter int DEPTH = 64,
   parameter int AW = 6,
   parameter int FC_DEPTH = 64,
   parameter int FC_AW = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   input  logic              param_we,
   input  dcr_pkg::param_type param_wdata,
   output dcr_pkg::param_type param_rdata,
   input  logic              hist_we,
   input  logic [AW-1:0]     hist_addr,
   input  logic [31:0]       hist_wdata,
   output logic [31:0]       hist_rdata,
   input  logic              fill_we,
   input  logic [FC_AW-1:0]  fill_addr,
   input  logic [1:0]        fill_wdata,
   output logic [1:0]        fill_rdata
);
   import dcr_pkg::*;

   param_type   param_mem [DEPTH];
   logic [31:0] hist_mem [DEPTH];
   logic [1:0]  fill_ff [FC_DEPTH];
   param_type   param_rdata_ff;
   logic [31:0] hist_rdata_ff;
   logic [1:0]  fill_rdata_ff;

   always_ff @(posedge clock) begin
      if (param_we) begin
         param_mem[rd_addr] <= param_wdata;
      end
      if (rd_en) begin
         param_rdata_ff <= param_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_addr] <= hist_wdata;
      end
      if (rd_en) begin
         hist_rdata_ff <= hist_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FC_DEPTH; i++) begin
            fill_ff[i] <= 2'd0;
         end
      end else if (fill_we) begin
         fill_ff[fill_addr] <= fill_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         fill_rdata_ff <= fill_ff[FC_AW'(rd_addr)];
      end
   end

   assign param_rdata = param_rdata_ff;
   assign hist_rdata  = hist_rdata_ff;
   assign fill_rdata  = fill_rdata_ff;
endmodule

### design/dcr_datapath.sv
// multiply-accumulate and rounding requantize with clamp
// depends on dcr_pkg
module dcr_datapath (
   input  logic               clock,
   input  dcr_pkg::stage_type ctl,
   input  dcr_pkg::param_type prm,
   input  logic signed [15:0] x0,
   input  logic signed [15:0] x1,
   input  logic signed [15:0] x2,
   input  logic signed [15:0] act_min,
   input  logic signed [15:0] act_max,
   output logic signed [15:0] res_value
);
   import dcr_pkg::*;

   logic signed [23:0] p0_ff, p1_ff, p2_ff;
   logic signed [31:0] bias_ff, mult_ff, acc_ff;
   logic signed [5:0]  shift_ff;
   logic [5:0]         sh_ff;
   logic signed [63:0] prod_ff;
   logic signed [5:0]  e;
   logic signed [6:0]  s7;
   logic signed [63:0] v, r, rs;

   always_comb begin
      e = shift_ff;
      if (shift_ff == -6'sd32) begin
         e = -6'sd31;
      end else if (shift_ff == 6'sd31) begin
         e = 6'sd30;
      end
      s7 = 7'sd31 - 7'(e);
   end

   always_ff @(posedge clock) begin
      if (ctl.rd) begin
         p0_ff    <= prm.w0 * x0;
         p1_ff    <= prm.w1 * x1;
         p2_ff    <= prm.w2 * x2;
         bias_ff  <= prm.bias;
         mult_ff  <= prm.mult;
         shift_ff <= prm.shift;
      end
      if (ctl.mac) begin
         acc_ff <= bias_ff + 32'(p0_ff) + 32'(p1_ff) + 32'(p2_ff);
         sh_ff  <= 6'(s7);
      end
      if (ctl.mul) begin
         prod_ff <= 64'(acc_ff) * 64'(mult_ff);
      end
   end

   always_comb begin
      v = prod_ff + (64'sd1 <<< (sh_ff - 6'd1));
      r = v >>> sh_ff;
      rs = r;
      if (r > 64'sd2147483647) begin
         rs = 64'sd2147483647;
      end
      if (r < -64'sd2147483648) begin
         rs = -64'sd2147483648;
      end
      if (rs > 64'(act_max)) begin
         rs = 64'(act_max);
      end
      if (rs < 64'(act_min)) begin
         rs = 64'(act_min);
      end
      res_value = rs[15:0];
   end
endmodule

### design/depthwise_conv_3tap_requant.sv
// top level of the 3-tap depthwise convolution with per-channel requantize
// depends on dcr_pkg, dcr_store, dcr_datapath and the defines header
//
// req channel: a load word (op 0) stores the weights, bias, multiplier and
// shift of one channel and is done in the cycle it is accepted. a sample
// word (op 1) shifts the channel's two-sample history; once two earlier
// samples are held it produces one rsp word with the clamped output.
// words addressing a channel at or above MAX_CHANNELS are dropped.
// a sample word passes memory read at accept, then tap products, accumulate,
// 32x32 multiply, round and clamp before rsp valid.
// the block holds one sample word at a time, so a new word is taken only
// once the last sample is through; loads every cycle while none is in flight.
// req_stall is high while a sample word is in flight.
// the output register lets a new word be accepted while a rsp word waits;
// under rsp_stall the finished value waits in the last stage.
// reset clears fill counts, control state and sets the clamp registers to
// the full int16 range; no clearing pass is needed.
// csr: act_min at 0x0, act_max at 0x4; the user must write them only while idle, the block does not enforce this.
module depthwise_conv_3tap_requant #(
   parameter int MAX_CHANNELS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic [5:0]         req_channel,
   input  logic               req_first_frame,
   input  logic signed [15:0] req_sample,
   input  logic signed [7:0]  req_weight_tap0,
   input  logic signed [7:0]  req_weight_tap1,
   input  logic signed [7:0]  req_weight_tap2,
   input  logic signed [31:0] req_bias,
   input  logic signed [31:0] req_multiplier,
   input  logic signed [5:0]  req_shift_amount,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_out_value,
   output logic [5:0]         rsp_out_channel,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import dcr_pkg::*;
   `include "depthwise_conv_3tap_requant_defines.svh"

   localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int FC_DEPTH = (MAX_CHANNELS < 64) ? MAX_CHANNELS : 64;
   localparam int FC_AW = (FC_DEPTH > 1) ? $clog2(FC_DEPTH) : 1;

   logic [2:0]         state_ff, state_in;
   logic signed [15:0] act_min_ff, act_max_ff;
   logic [5:0]         ch_ff;
   logic               first_ff;
   logic signed [15:0] samp_ff;
   logic               rsp_valid_ff;
   logic signed [15:0] rsp_value_ff;
   logic [5:0]         rsp_ch_ff;

   logic               accept, in_range, fin_go;
   param_type          wparam, rparam;
   logic [31:0]        hist;
   logic [1:0]         fill_cur, fc, fc_new;
   stage_type          ctl;
   logic signed [15:0] res_value;

   assign in_range = 32'(req_channel) < MAX_CHANNELS;
   assign req_stall = state_ff != S_IDLE;
   assign accept = req_valid && !req_stall;
   assign fin_go = state_ff == S_FIN && !(rsp_valid_ff && rsp_stall);

   assign wparam = '{shift: req_shift_amount, mult: req_multiplier, bias: req_bias,
                     w2: req_weight_tap2, w1: req_weight_tap1, w0: req_weight_tap0};

   assign fc = first_ff ? 2'd0 : fill_cur;
   assign fc_new = (fc < 2'd2) ? fc + 2'd1 : fc;

   assign ctl = '{rd: state_ff == S_RD, mac: state_ff == S_MAC, mul: state_ff == S_MUL};

   dcr_store #(.DEPTH(MAX_CHANNELS), .AW(AW), .FC_DEPTH(FC_DEPTH), .FC_AW(FC_AW)) u_store (
      .clock(clock),
      .reset(reset),
      .rd_en(accept && in_range && req_op == OP_SAMPLE),
      .rd_addr(AW'(req_channel)),
      .param_we(accept && in_range && req_op == OP_LOAD),
      .param_wdata(wparam),
      .param_rdata(rparam),
      .hist_we(state_ff == S_RD),
      .hist_addr(AW'(ch_ff)),
      .hist_wdata({samp_ff, hist[31:16]}),
      .hist_rdata(hist),
      .fill_we(state_ff == S_RD),
      .fill_addr(FC_AW'(ch_ff)),
      .fill_wdata(fc_new),
      .fill_rdata(fill_cur)
   );

   dcr_datapath u_datapath (
      .clock(clock),
      .ctl(ctl),
      .prm(rparam),
      .x0(hist[15:0]),
      .x1(hist[31:16]),
      .x2(samp_ff),
      .act_min(act_min_ff),
      .act_max(act_max_ff),
      .res_value(res_value)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && in_range && req_op == OP_SAMPLE) state_in = S_RD;
         end
         S_RD:  state_in = (fc == 2'd2) ? S_MAC : S_IDLE;
         S_MAC: state_in = S_MUL;
         S_MUL: state_in = S_FIN;
         S_FIN: begin
            if (fin_go) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         act_min_ff <= -16'sd32768;
         act_max_ff <= 16'sd32767;
      end else begin
         state_ff <= state_in;
         if (fin_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (psel && penable && pwrite) begin
            unique case (paddr[2])
               REG_ACT_MIN: act_min_ff <= pwdata[15:0];
               REG_ACT_MAX: act_max_ff <= pwdata[15:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ch_ff    <= req_channel;
         first_ff <= req_first_frame;
         samp_ff  <= req_sample;
      end
      if (fin_go) begin
         rsp_value_ff <= res_value;
         rsp_ch_ff    <= ch_ff;
      end
   end

   assign prdata = (paddr[2] == REG_ACT_MAX) ? 32'(act_max_ff) : 32'(act_min_ff);
   assign pready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_out_channel = rsp_ch_ff;

   `DCR_ASSERT(a_sample_reads, clock, reset,
      accept && in_range && req_op == OP_SAMPLE |=> state_ff == S_RD)
   `DCR_ASSERT(a_mac_after_read, clock, reset,
      state_ff == S_MAC |-> $past(state_ff) == S_RD)
   `DCR_ASSERT(a_fin_delivers, clock, reset,
      fin_go |=> rsp_valid_ff && state_ff == S_IDLE)
endmodule
